// ===== src/cctl_pkg.sv =====
// ----------------------------------------------------------------------------
// cctl_pkg
// Shared constants of the cache tag store: default sizes, field widths,
// associativity codes and configuration register indexes.
// ----------------------------------------------------------------------------
package cctl_pkg;

	// default storage sizes
	localparam int MAX_LINES_DEF = 128;
	localparam int ADDR_BITS_DEF = 32;

	// fixed field widths of the ports
	localparam int FIELD_W    = 32;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;

	// associativity codes
	localparam logic [1:0] MODE_DIRECT = 2'd0;
	localparam logic [1:0] MODE_SET4   = 2'd1;
	localparam logic [1:0] MODE_FULL   = 2'd2;
	localparam logic [1:0] MODE_RSVD   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ASSOC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINES  = 2'd2;

endpackage

// ===== src/cctl_ram.sv =====
// ----------------------------------------------------------------------------
// cctl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cctl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/configurable_cache_tag_lru_core.sv =====
// Each accepted word runs a search pass and a re-rank pass over its set; the ways per set
// are 1 direct mapped, at most 4 four-way and all lines in use fully associative.
// Both passes go one way per cycle through the tag and rank RAM read ports, with the decide
// state between them and the done state after them; a new word is taken only when idle.
// Reserved mode: the strobe is raised in the cycle after the word, with no hit or eviction.
// Reset and any write to the associativity, offset or lines register clear all valid bits and ranks.
// ----------------------------------------------------------------------------
// configurable_cache_tag_lru_core
// Cache tag store with least recently used replacement. Splits each address
// into offset, set index and tag, searches the set one way per cycle, fills
// or evicts a way, then re-ranks the set with a second sequential pass.
// ----------------------------------------------------------------------------
module configurable_cache_tag_lru_core
	import cctl_pkg::*;
#(
	parameter int MAX_LINES = MAX_LINES_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// command
	input  logic                  start,
	input  logic [FIELD_W-1:0]    addr,
	output logic                  busy,
	// result
	output logic                  done,
	output logic                  hit,
	output logic                  evicted,
	output logic [FIELD_W-1:0]    evicted_tag
);

	localparam int LW     = $clog2(MAX_LINES);
	localparam int LB_CAP = $clog2(MAX_LINES + 1) - 1;
	localparam int AW     = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
	localparam int OBW    = $clog2(ADDR_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_TOUCH,
		ST_DONE
	} state_t;

	// configuration registers
	logic [1:0] assoc_q;
	logic [4:0] offset_q;
	logic [2:0] line_bits_q;

	// per line status bits
	logic [MAX_LINES-1:0] line_valid_q;
	logic [MAX_LINES-1:0] rank_wr_q;

	// sequencer state
	state_t          state_q;
	logic [AW-1:0]   tag_q;
	logic [LW-1:0]   base_q;
	logic [LW-1:0]   k_q;
	logic            more_q;
	logic            pend_s1;
	logic [LW-1:0]   k_s1;
	logic [LW-1:0]   idx_s1;
	logic            hit_fnd_q;
	logic [LW-1:0]   hit_w_q;
	logic [LW-1:0]   hit_r_q;
	logic            inv_fnd_q;
	logic [LW-1:0]   inv_w_q;
	logic [LW-1:0]   inv_r_q;
	logic            vic_fnd_q;
	logic [LW-1:0]   vic_w_q;
	logic [LW-1:0]   vic_r_q;
	logic [AW-1:0]   vic_tag_q;
	logic [LW-1:0]   sel_w_q;
	logic [LW-1:0]   sel_r_q;
	logic            done_q;
	logic            hit_q;
	logic            evicted_q;
	logic [AW-1:0]   evtag_q;

	// geometry and address split
	logic [2:0]     lb_eff;
	logic [2:0]     wl;
	logic [2:0]     iw_raw;
	logic [2:0]     iw;
	logic [OBW-1:0] ob;
	logic [OBW-1:0] ob_rem;
	logic [AW-1:0]  a_v;
	logic [LW-1:0]  set_v;
	logic [LW-1:0]  base_v;
	logic [AW-1:0]  tag_v;
	logic [LW-1:0]  last_v;

	// ram ports
	logic [LW-1:0] rd_addr;
	logic [AW-1:0] tag_rdata;
	logic [LW-1:0] rank_rdata;
	logic          tag_we;
	logic [LW-1:0] tag_waddr;
	logic          rank_we;
	logic [LW-1:0] rank_wdata;
	logic [LW-1:0] rank_cur;
	logic          valid_cur;
	logic          cfg_hit;

	// geometry from the configuration registers
	always_comb begin
		lb_eff = (int'(line_bits_q) > LB_CAP) ? 3'(LB_CAP) : line_bits_q;
		unique case (assoc_q)
			MODE_SET4: wl = (lb_eff < 3'd2) ? lb_eff : 3'd2;
			MODE_FULL: wl = lb_eff;
			default:   wl = 3'd0;
		endcase
		iw_raw = lb_eff - wl;
		ob     = (int'(offset_q) > ADDR_BITS) ? OBW'(ADDR_BITS) : OBW'(offset_q);
		ob_rem = OBW'(ADDR_BITS) - ob;
		iw     = ((OBW + 3)'(iw_raw) > (OBW + 3)'(ob_rem)) ? ob_rem[2:0] : iw_raw;
		last_v = ~({LW{1'b1}} << wl);
	end

	// address split into set base and tag
	always_comb begin
		a_v    = addr[AW-1:0];
		set_v  = LW'(a_v >> ob) & ~({LW{1'b1}} << iw);
		base_v = LW'(set_v << wl);
		tag_v  = a_v >> ((OBW + 1)'(ob) + (OBW + 1)'(iw));
	end

	// ram addressing, rank read with reset value for lines never ranked
	always_comb begin
		rd_addr    = base_q + k_q;
		tag_we     = (state_q == ST_DECIDE) && !hit_fnd_q;
		tag_waddr  = base_q + (inv_fnd_q ? inv_w_q : vic_w_q);
		valid_cur  = line_valid_q[idx_s1];
		rank_cur   = rank_wr_q[idx_s1] ? rank_rdata : (idx_s1 & last_v);
		rank_we    = (state_q == ST_TOUCH) && pend_s1;
		if (k_s1 == sel_w_q) begin
			rank_wdata = '0;
		end else if (rank_cur < sel_r_q) begin
			rank_wdata = rank_cur + 1'b1;
		end else begin
			rank_wdata = rank_cur;
		end
		cfg_hit = cfg_we && (cfg_index == REG_ASSOC || cfg_index == REG_OFFSET ||
			cfg_index == REG_LINES);
	end

	cctl_ram #(
		.WIDTH(AW),
		.DEPTH(MAX_LINES)
	) u_tag_ram (
		.clk  (clk),
		.we   (tag_we),
		.waddr(tag_waddr),
		.wdata(tag_q),
		.raddr(rd_addr),
		.rdata(tag_rdata)
	);

	cctl_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_LINES)
	) u_rank_ram (
		.clk  (clk),
		.we   (rank_we),
		.waddr(idx_s1),
		.wdata(rank_wdata),
		.raddr(rd_addr),
		.rdata(rank_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assoc_q     <= MODE_DIRECT;
			offset_q    <= 5'd0;
			line_bits_q <= 3'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ASSOC:  assoc_q     <= cfg_data[1:0];
				REG_OFFSET: offset_q    <= cfg_data[4:0];
				REG_LINES:  line_bits_q <= cfg_data[2:0];
				default:    ;
			endcase
		end
	end

	// valid and ranked bits, flushed on a write to the associativity, offset or lines register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q <= '0;
			rank_wr_q    <= '0;
		end else if (cfg_hit) begin
			line_valid_q <= '0;
			rank_wr_q    <= '0;
		end else begin
			if (tag_we) begin
				line_valid_q[tag_waddr] <= 1'b1;
			end
			if (rank_we) begin
				rank_wr_q[idx_s1] <= 1'b1;
			end
		end
	end

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tag_q     <= '0;
			base_q    <= '0;
			k_q       <= '0;
			more_q    <= 1'b0;
			pend_s1   <= 1'b0;
			k_s1      <= '0;
			idx_s1    <= '0;
			hit_fnd_q <= 1'b0;
			hit_w_q   <= '0;
			hit_r_q   <= '0;
			inv_fnd_q <= 1'b0;
			inv_w_q   <= '0;
			inv_r_q   <= '0;
			vic_fnd_q <= 1'b0;
			vic_w_q   <= '0;
			vic_r_q   <= '0;
			vic_tag_q <= '0;
			sel_w_q   <= '0;
			sel_r_q   <= '0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			evicted_q <= 1'b0;
			evtag_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				// take a word, latch set base and tag
				ST_IDLE: begin
					if (start) begin
						if (assoc_q == MODE_RSVD) begin
							hit_q     <= 1'b0;
							evicted_q <= 1'b0;
							evtag_q   <= '0;
							done_q    <= 1'b1;
							state_q   <= ST_DONE;
						end else begin
							tag_q     <= tag_v;
							base_q    <= base_v;
							k_q       <= '0;
							more_q    <= 1'b1;
							pend_s1   <= 1'b0;
							hit_fnd_q <= 1'b0;
							inv_fnd_q <= 1'b0;
							vic_fnd_q <= 1'b0;
							state_q   <= ST_SEARCH;
						end
					end
				end
				// one way per cycle: hit, first invalid and lru candidate
				ST_SEARCH: begin
					pend_s1 <= more_q;
					k_s1    <= k_q;
					idx_s1  <= rd_addr;
					if (more_q) begin
						if (k_q == last_v) begin
							more_q <= 1'b0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					if (pend_s1) begin
						if (!hit_fnd_q && valid_cur && tag_rdata == tag_q) begin
							hit_fnd_q <= 1'b1;
							hit_w_q   <= k_s1;
							hit_r_q   <= rank_cur;
						end
						if (!inv_fnd_q && !valid_cur) begin
							inv_fnd_q <= 1'b1;
							inv_w_q   <= k_s1;
							inv_r_q   <= rank_cur;
						end
						if (!vic_fnd_q && (rank_cur == last_v || k_s1 == last_v)) begin
							vic_fnd_q <= 1'b1;
							vic_w_q   <= k_s1;
							vic_r_q   <= rank_cur;
							vic_tag_q <= tag_rdata;
						end
						if (k_s1 == last_v) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				// pick hit, fill or evict; tag ram written here
				ST_DECIDE: begin
					priority if (hit_fnd_q) begin
						sel_w_q   <= hit_w_q;
						sel_r_q   <= hit_r_q;
						hit_q     <= 1'b1;
						evicted_q <= 1'b0;
						evtag_q   <= '0;
					end else if (inv_fnd_q) begin
						sel_w_q   <= inv_w_q;
						sel_r_q   <= inv_r_q;
						hit_q     <= 1'b0;
						evicted_q <= 1'b0;
						evtag_q   <= '0;
					end else begin
						sel_w_q   <= vic_w_q;
						sel_r_q   <= vic_r_q;
						hit_q     <= 1'b0;
						evicted_q <= 1'b1;
						evtag_q   <= vic_tag_q;
					end
					k_q     <= '0;
					more_q  <= 1'b1;
					pend_s1 <= 1'b0;
					state_q <= ST_TOUCH;
				end
				// re-rank the set one way per cycle
				ST_TOUCH: begin
					pend_s1 <= more_q;
					k_s1    <= k_q;
					idx_s1  <= rd_addr;
					if (more_q) begin
						if (k_q == last_v) begin
							more_q <= 1'b0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					if (pend_s1 && k_s1 == last_v) begin
						done_q  <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				// result word on the ports
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// outputs
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign hit         = hit_q;
	assign evicted     = evicted_q;
	assign evicted_tag = FIELD_W'(evtag_q);

endmodule
